// ----- rtl/core/nfcsel_pkg.sv -----
// types, codes and constants shared by the type A selection sequencer
`default_nettype none

package nfcsel_pkg;

  localparam int MAX_CASCADE_LEVELS  = 3;
  localparam int UID_BYTES_PER_LEVEL = 4;
  localparam int UID_MAX_BYTES       = 12;
  localparam int UID_COUNT_W         = 4;
  localparam int SAK_CASCADE_BIT     = 2;

  localparam logic [7:0] SEL_CODE_BASE = 8'h93;
  localparam logic [7:0] NVB_ANTICOLL  = 8'h20;
  localparam logic [7:0] NVB_SELECT    = 8'h70;
  localparam logic [7:0] CASCADE_TAG   = 8'h88;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_FRAME = 1'b1
  } command_t;

  typedef enum logic [2:0] {
    ACT_REQA   = 3'd0,
    ACT_SEL    = 3'd1,
    ACT_SELECT = 3'd2,
    ACT_DONE   = 3'd3,
    ACT_FAIL   = 3'd4,
    ACT_IGNORE = 3'd5
  } action_t;

  typedef struct packed {
    command_t   command;
    logic [7:0] rx_count;
    logic [7:0] rx_byte0;
    logic [7:0] rx_byte1;
    logic [7:0] rx_byte2;
    logic [7:0] rx_byte3;
    logic [7:0] rx_byte4;
  } item_t;

  typedef struct packed {
    action_t                  action;
    logic [7:0]               tx_byte0;
    logic [7:0]               tx_byte1;
    logic [7:0]               tx_byte2;
    logic [7:0]               tx_byte3;
    logic [7:0]               tx_byte4;
    logic [7:0]               tx_byte5;
    logic [7:0]               tx_byte6;
    logic [UID_COUNT_W-1:0]   uid_length;
    logic [63:0]              uid_low;
    logic [31:0]              uid_high;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/nfc_type_a_anticollision_sequencer.sv -----
// top level of the reader-side type A card selection sequencer
//
// usage: each transaction on the item channel is either a start command
// or the summary of one frame received from the card (byte count plus
// the first five bytes). each item yields exactly one transaction on the
// result channel: send REQA, send SEL (anticollision), send SELECT with
// CRC, done with the assembled uid, failed, or ignored.
// both channels are valid/ready; an item is taken when item_valid and
// item_ready are high at a clock edge, a result likewise.
// an accepted item is held in the input register; when it advances, its
// result is loaded into the result register and result_valid rises, and the
// result is taken at an edge where result_ready is high.
// throughput: one item per cycle while the receiver does not stall, set by
// the single pass from input register through the state update logic into
// the result register.
// when the receiver stalls, the result register holds, the input register
// holds its item, and item_ready drops until the result is taken.
// reset (rst, synchronous) empties both registers and returns the
// sequence to idle with an empty uid.
`default_nettype none

module nfc_type_a_anticollision_sequencer
  import nfcsel_pkg::*;
#(
  parameter int CASCADE_LEVELS = MAX_CASCADE_LEVELS
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  output logic         item_ready,
  input  wire item_t   item,
  output logic         result_valid,
  input  wire logic    result_ready,
  output result_t      result
);

  logic    s1_valid;
  item_t   s1_item;
  logic    advance;
  result_t step_result;

  assign advance    = s1_valid && (!result_valid || result_ready);
  assign item_ready = !s1_valid || advance;

  nfcsel_core #(
    .CASCADE_LEVELS (CASCADE_LEVELS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (s1_item),
    .result (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (item_ready) begin
        s1_valid <= item_valid;
      end
      if (advance) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      s1_item <= item;
    end
    if (advance) begin
      result <= step_result;
    end
  end

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !s1_valid && !result_valid)
    else $error("pipeline not empty after reset");

  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> result_valid)
    else $error("advanced transaction lost from result register");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_item))
    else $error("input register changed while blocked");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    advance |-> !result_valid || result_ready)
    else $error("result overwritten before taken");

endmodule

`default_nettype wire

// ----- rtl/core/nfcsel_core.sv -----
// selection state, uid store and next-result logic for one transaction
`default_nettype none

module nfcsel_core
  import nfcsel_pkg::*;
#(
  parameter int CASCADE_LEVELS = MAX_CASCADE_LEVELS
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    fire,
  input  wire item_t   item,
  output result_t      result
);

  localparam int UID_DEPTH = UID_BYTES_PER_LEVEL * CASCADE_LEVELS;
  localparam int UID_IDX_W = UID_COUNT_W + 1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ATQA,
    PH_UID,
    PH_SAK
  } phase_t;

  phase_t                 phase;
  phase_t                 phase_next;
  logic [1:0]             cascade_index;
  logic [1:0]             cascade_index_next;
  logic [UID_COUNT_W-1:0] uid_count;
  logic [UID_COUNT_W-1:0] uid_count_next;
  logic [7:0]             uid_store [UID_DEPTH];

  logic [7:0]             wr_byte [UID_BYTES_PER_LEVEL];
  logic                   wr_en   [UID_BYTES_PER_LEVEL];
  logic                   store_write;
  logic                   tagged_chunk;
  logic [2:0]             chunk_len;
  logic [7:0]             level_code;
  logic [7:0]             next_level_code;
  logic [2:0]             cascade_plus;
  logic                   go_deeper;
  logic [7:0]             uid_bytes [UID_MAX_BYTES];
  logic [UID_IDX_W-1:0]   uid_written;

  assign tagged_chunk    = (item.rx_byte0 == CASCADE_TAG);
  assign chunk_len       = tagged_chunk ? 3'd3 : 3'd4;
  assign level_code      = SEL_CODE_BASE + {5'd0, cascade_index, 1'b0};
  assign cascade_plus    = {1'b0, cascade_index} + 3'd1;
  assign next_level_code = SEL_CODE_BASE + {4'd0, cascade_plus, 1'b0};
  assign go_deeper       = item.rx_byte0[SAK_CASCADE_BIT] &&
                           (cascade_plus < 3'(CASCADE_LEVELS));

  always_comb begin
    if (tagged_chunk) begin
      wr_byte[0] = item.rx_byte1;
      wr_byte[1] = item.rx_byte2;
      wr_byte[2] = item.rx_byte3;
      wr_byte[3] = item.rx_byte3;
    end else begin
      wr_byte[0] = item.rx_byte0;
      wr_byte[1] = item.rx_byte1;
      wr_byte[2] = item.rx_byte2;
      wr_byte[3] = item.rx_byte3;
    end
  end

  always_comb begin
    uid_written = '0;
    for (int k = 0; k < UID_BYTES_PER_LEVEL; k++) begin
      wr_en[k] = (3'(k) < chunk_len) &&
                 (UID_IDX_W'(uid_count) + UID_IDX_W'(k) < UID_IDX_W'(UID_DEPTH));
      uid_written = uid_written + UID_IDX_W'(wr_en[k]);
    end
  end

  // uid bytes at or above the fill count read as zero
  always_comb begin
    for (int i = 0; i < UID_MAX_BYTES; i++) begin
      uid_bytes[i] = '0;
    end
    for (int i = 0; i < UID_DEPTH; i++) begin
      if (UID_IDX_W'(i) < UID_IDX_W'(uid_count)) begin
        uid_bytes[i] = uid_store[i];
      end
    end
  end

  always_comb begin
    result             = '0;
    result.action      = ACT_IGNORE;
    phase_next         = phase;
    cascade_index_next = cascade_index;
    uid_count_next     = uid_count;
    store_write        = 1'b0;
    if (item.command == CMD_START) begin
      result.action      = ACT_REQA;
      phase_next         = PH_ATQA;
      cascade_index_next = '0;
      uid_count_next     = '0;
    end else if (phase == PH_IDLE) begin
      result.action = ACT_IGNORE;
    end else if (item.rx_count == '0) begin
      result.action = ACT_FAIL;
      phase_next    = PH_IDLE;
    end else begin
      case (phase)
        PH_ATQA: begin
          result.action   = ACT_SEL;
          result.tx_byte0 = level_code;
          result.tx_byte1 = NVB_ANTICOLL;
          phase_next      = PH_UID;
        end
        PH_UID: begin
          result.action   = ACT_SELECT;
          result.tx_byte0 = level_code;
          result.tx_byte1 = NVB_SELECT;
          result.tx_byte2 = item.rx_byte0;
          result.tx_byte3 = item.rx_byte1;
          result.tx_byte4 = item.rx_byte2;
          result.tx_byte5 = item.rx_byte3;
          result.tx_byte6 = item.rx_byte4;
          store_write     = 1'b1;
          uid_count_next  = UID_COUNT_W'(UID_IDX_W'(uid_count) + uid_written);
          phase_next      = PH_SAK;
        end
        PH_SAK: begin
          if (go_deeper) begin
            result.action      = ACT_SEL;
            result.tx_byte0    = next_level_code;
            result.tx_byte1    = NVB_ANTICOLL;
            cascade_index_next = cascade_plus[1:0];
            phase_next         = PH_UID;
          end else begin
            result.action     = ACT_DONE;
            result.uid_length = uid_count;
            result.uid_low    = {uid_bytes[7], uid_bytes[6], uid_bytes[5], uid_bytes[4],
                                 uid_bytes[3], uid_bytes[2], uid_bytes[1], uid_bytes[0]};
            result.uid_high   = {uid_bytes[11], uid_bytes[10], uid_bytes[9], uid_bytes[8]};
            phase_next        = PH_IDLE;
          end
        end
        default: begin
          result.action = ACT_IGNORE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      cascade_index <= '0;
      uid_count     <= '0;
    end else if (fire) begin
      phase         <= phase_next;
      cascade_index <= cascade_index_next;
      uid_count     <= uid_count_next;
    end
  end

  // uid store, no reset: entries at or above the fill count are never reported
  always_ff @(posedge clk) begin
    if (fire && store_write) begin
      for (int e = 0; e < UID_DEPTH; e++) begin
        for (int k = 0; k < UID_BYTES_PER_LEVEL; k++) begin
          if (wr_en[k] &&
              (UID_IDX_W'(uid_count) + UID_IDX_W'(k) == UID_IDX_W'(e))) begin
            uid_store[e] <= wr_byte[k];
          end
        end
      end
    end
  end

  a_uid_count_bound: assert property (@(posedge clk) disable iff (rst)
    uid_count <= UID_COUNT_W'(UID_DEPTH))
    else $error("uid fill count past store depth");

  a_cascade_bound: assert property (@(posedge clk) disable iff (rst)
    {1'b0, cascade_index} < 3'(CASCADE_LEVELS))
    else $error("cascade level past configured depth");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    fire && item.command == CMD_START |=>
      uid_count == '0 && cascade_index == '0 && phase == PH_ATQA)
    else $error("start did not reopen selection");

  a_uid_only_when_waiting: assert property (@(posedge clk) disable iff (rst)
    fire && result.action == ACT_SELECT |-> phase == PH_UID)
    else $error("select issued outside uid phase");

endmodule

`default_nettype wire
